// ===== sv/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants for the thermal protection level monitor
// Holds the register map, the level codes, reset values and state structs.
// ----------------------------------------------------------------------------
package tpm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 8;
    localparam int LEVEL_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_TRIP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_TRIP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 3'd4;

    // Protection level codes
    localparam logic [LEVEL_W-1:0] LEVEL_NORMAL = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_FIRST  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_SECOND = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_UNUSED = 2'd3;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RST_LEVEL1_TRIP    = 12'd945;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL1_RELEASE = 12'd1064;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL2_TRIP    = 12'd741;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL2_RELEASE = 12'd863;
    localparam logic [COUNT_W-1:0]  RST_DEBOUNCE_LIMIT = 8'd30;

    typedef struct packed {
        logic [SAMPLE_W-1:0] level1_trip;
        logic [SAMPLE_W-1:0] level1_release;
        logic [SAMPLE_W-1:0] level2_trip;
        logic [SAMPLE_W-1:0] level2_release;
        logic [COUNT_W-1:0]  debounce_limit;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [COUNT_W-1:0] trip_count;
        logic [COUNT_W-1:0] release_count;
    } state_t;

endpackage

// ===== sv/tpm_level_update.sv =====
// ----------------------------------------------------------------------------
// tpm_level_update: next-state logic of the protection level
// Compares one sample against the thresholds of the current level and
// advances, clears or rolls over the debounce counters.
// ----------------------------------------------------------------------------
module tpm_level_update
(
    input  tpm_pkg::cfg_t                    cfg,
    input  tpm_pkg::state_t                  state,
    input  logic [tpm_pkg::SAMPLE_W-1:0]     sample,
    output tpm_pkg::state_t                  state_next
);

    logic [tpm_pkg::COUNT_W-1:0] trip_inc;
    logic [tpm_pkg::COUNT_W-1:0] release_inc;
    logic                        trip_over;
    logic                        release_over;

    // Counters wrap at 8 bits
    assign trip_inc     = state.trip_count + tpm_pkg::COUNT_W'(1);
    assign release_inc  = state.release_count + tpm_pkg::COUNT_W'(1);
    assign trip_over    = trip_inc > cfg.debounce_limit;
    assign release_over = release_inc > cfg.debounce_limit;

    always_comb
    begin
        state_next = state;
        unique case (state.level)
            tpm_pkg::LEVEL_NORMAL:
            begin
                if (sample < cfg.level1_trip)
                begin
                    if (trip_over)
                    begin
                        state_next.level      = tpm_pkg::LEVEL_FIRST;
                        state_next.trip_count = '0;
                    end
                    else
                    begin
                        state_next.trip_count = trip_inc;
                    end
                end
                else
                begin
                    state_next.trip_count = '0;
                end
            end
            tpm_pkg::LEVEL_FIRST:
            begin
                if (sample < cfg.level2_trip)
                begin
                    if (trip_over)
                    begin
                        state_next.level      = tpm_pkg::LEVEL_SECOND;
                        state_next.trip_count = '0;
                    end
                    else
                    begin
                        state_next.trip_count = trip_inc;
                    end
                end
                else if (sample > cfg.level1_release)
                begin
                    if (release_over)
                    begin
                        state_next.level         = tpm_pkg::LEVEL_NORMAL;
                        state_next.release_count = '0;
                    end
                    else
                    begin
                        state_next.release_count = release_inc;
                    end
                end
                else
                begin
                    state_next.trip_count    = '0;
                    state_next.release_count = '0;
                end
            end
            tpm_pkg::LEVEL_SECOND:
            begin
                if (sample > cfg.level2_release)
                begin
                    if (release_over)
                    begin
                        state_next.level         = tpm_pkg::LEVEL_FIRST;
                        state_next.release_count = '0;
                    end
                    else
                    begin
                        state_next.release_count = release_inc;
                    end
                end
                else
                begin
                    state_next.release_count = '0;
                end
            end
            default:
            begin
                // unreachable code: hold everything
                state_next = state;
            end
        endcase
    end

endmodule

// ===== sv/thermal_protection_level_monitor_core.sv =====
// ----------------------------------------------------------------------------
// thermal_protection_level_monitor_core: debounced three-level thermal monitor
// Takes thermistor ADC samples and reports the protection level per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one 12-bit ADC sample per
//   request; a lower code means a hotter part. Master stream (m_tvalid/
//   m_tready/m_tdata) returns one protection level per sample, in order.
//   The cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the four
//   thresholds and the debounce limit; cfg_ready is always high. Write it
//   only while no sample is in flight.
//   A sample is registered on acceptance, and the level update runs between
//   that input register and the result register, where m_tvalid rises; one
//   sample is taken every cycle while the result register can move on. The
//   rate is set by the level/counter update loop through the state register.
//   When the receiver stalls, the result register holds and the input
//   register takes one more sample; s_tready drops once both are full.
//   Reset clears level and counters to zero, empties both registers and
//   loads the default thresholds (945, 1064, 741, 863) and limit 30.
// ----------------------------------------------------------------------------
module thermal_protection_level_monitor_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,    // [11:0] temp_sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,    // [1:0] protection_level
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tpm_pkg::cfg_t                   cfg_reg;
    tpm_pkg::state_t                 state_reg;
    tpm_pkg::state_t                 state_next;
    logic                            in_valid_reg;
    logic [tpm_pkg::SAMPLE_W-1:0]    sample_reg;
    logic                            out_valid_reg;
    logic [tpm_pkg::LEVEL_W-1:0]     level_out_reg;
    logic                            advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(8 - tpm_pkg::LEVEL_W){1'b0}}, level_out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level1_trip    <= tpm_pkg::RST_LEVEL1_TRIP;
            cfg_reg.level1_release <= tpm_pkg::RST_LEVEL1_RELEASE;
            cfg_reg.level2_trip    <= tpm_pkg::RST_LEVEL2_TRIP;
            cfg_reg.level2_release <= tpm_pkg::RST_LEVEL2_RELEASE;
            cfg_reg.debounce_limit <= tpm_pkg::RST_DEBOUNCE_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tpm_pkg::CFG_LEVEL1_TRIP:    cfg_reg.level1_trip    <= cfg_data;
                tpm_pkg::CFG_LEVEL1_RELEASE: cfg_reg.level1_release <= cfg_data;
                tpm_pkg::CFG_LEVEL2_TRIP:    cfg_reg.level2_trip    <= cfg_data;
                tpm_pkg::CFG_LEVEL2_RELEASE: cfg_reg.level2_release <= cfg_data;
                tpm_pkg::CFG_DEBOUNCE_LIMIT:
                    cfg_reg.debounce_limit <= cfg_data[tpm_pkg::COUNT_W-1:0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            sample_reg <= s_tdata[tpm_pkg::SAMPLE_W-1:0];
        end
    end

    tpm_level_update u_level_update
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .sample     (sample_reg),
        .state_next (state_next)
    );

    // Commit state and result together when the sample moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            level_out_reg <= state_next.level;
        end
    end

    a_level_reachable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.level != tpm_pkg::LEVEL_UNUSED)
        else $error("protection level reached unused code");

    a_level_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg.level))
        else $error("level changed without a sample");

    a_level_change_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (state_next.level != state_reg.level)
        |=> (state_reg.trip_count == '0) || (state_reg.release_count == '0))
        else $error("level changed without clearing its counter");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid && (m_tdata[tpm_pkg::LEVEL_W-1:0] == state_reg.level))
        else $error("result does not match committed level");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with free register");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the thermal protection level monitor core
// Drives ADC samples with random gaps and back-pressure, rewrites the
// thresholds and debounce limit between phases, and checks every reported
// protection level against a cycle-free model of the level/counter update.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum int {PICK_HOT, PICK_COLD, PICK_MID, PICK_ANY} pick_t;

    localparam logic [tpm_pkg::CFG_IDX_W-1:0] CFG_LAST = tpm_pkg::CFG_DEBOUNCE_LIMIT;

    class level_checker;
        tpm_pkg::cfg_t        regs;
        tpm_pkg::state_t      st;
        logic [7:0]           level_q[$];
        int                   errors;

        function new();
            regs.level1_trip    = tpm_pkg::RST_LEVEL1_TRIP;
            regs.level1_release = tpm_pkg::RST_LEVEL1_RELEASE;
            regs.level2_trip    = tpm_pkg::RST_LEVEL2_TRIP;
            regs.level2_release = tpm_pkg::RST_LEVEL2_RELEASE;
            regs.debounce_limit = tpm_pkg::RST_DEBOUNCE_LIMIT;
            st     = '0;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: %0s", $realtime, msg);
        endfunction

        function void load_reg(logic [tpm_pkg::CFG_IDX_W-1:0] idx,
                               logic [tpm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tpm_pkg::CFG_LEVEL1_TRIP:    regs.level1_trip    = data;
                tpm_pkg::CFG_LEVEL1_RELEASE: regs.level1_release = data;
                tpm_pkg::CFG_LEVEL2_TRIP:    regs.level2_trip    = data;
                tpm_pkg::CFG_LEVEL2_RELEASE: regs.level2_release = data;
                tpm_pkg::CFG_DEBOUNCE_LIMIT:
                    regs.debounce_limit = data[tpm_pkg::COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // Counters wrap at 8 bits; the untouched counter keeps its value.
        function logic [tpm_pkg::LEVEL_W-1:0] next_level(logic [tpm_pkg::SAMPLE_W-1:0] s);
            case (st.level)
                tpm_pkg::LEVEL_NORMAL:
                begin
                    if (s < regs.level1_trip)
                    begin
                        st.trip_count = st.trip_count + 8'd1;
                        if (st.trip_count > regs.debounce_limit)
                        begin
                            st.level      = tpm_pkg::LEVEL_FIRST;
                            st.trip_count = '0;
                        end
                    end
                    else
                        st.trip_count = '0;
                end
                tpm_pkg::LEVEL_FIRST:
                begin
                    if (s < regs.level2_trip)
                    begin
                        st.trip_count = st.trip_count + 8'd1;
                        if (st.trip_count > regs.debounce_limit)
                        begin
                            st.level      = tpm_pkg::LEVEL_SECOND;
                            st.trip_count = '0;
                        end
                    end
                    else if (s > regs.level1_release)
                    begin
                        st.release_count = st.release_count + 8'd1;
                        if (st.release_count > regs.debounce_limit)
                        begin
                            st.level         = tpm_pkg::LEVEL_NORMAL;
                            st.release_count = '0;
                        end
                    end
                    else
                    begin
                        st.trip_count    = '0;
                        st.release_count = '0;
                    end
                end
                tpm_pkg::LEVEL_SECOND:
                begin
                    if (s > regs.level2_release)
                    begin
                        st.release_count = st.release_count + 8'd1;
                        if (st.release_count > regs.debounce_limit)
                        begin
                            st.level         = tpm_pkg::LEVEL_FIRST;
                            st.release_count = '0;
                        end
                    end
                    else
                        st.release_count = '0;
                end
                default: ;
            endcase
            return st.level;
        endfunction

        function void take_sample(logic [tpm_pkg::SAMPLE_W-1:0] s);
            level_q.push_back(8'(next_level(s)));
        endfunction

        function void check_level(logic [7:0] got);
            logic [7:0] want;
            if (level_q.size() == 0)
            begin
                flag($sformatf("level %0d reported with none pending", got));
                return;
            end
            want = level_q.pop_front();
            if (got !== want)
                flag($sformatf("protection level: expected %0d, got %0d", want, got));
        endfunction

        function int pending();
            return level_q.size();
        endfunction

        function void finish_check();
            if (level_q.size() != 0)
                flag($sformatf("%0d expected levels never arrived", level_q.size()));
        endfunction
    endclass

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata   = '0;     // [11:0] temp_sample
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [7:0]                      m_tdata;            // [1:0] protection_level
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tpm_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [tpm_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    level_checker chk = new();

    thermal_protection_level_monitor_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Result side: random stalls, with quiet stretches of no stall at all.
    initial
    begin : level_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(40, 0) == 0)
                rx_quiet = !rx_quiet;
            stall = rx_quiet ? 0 : $urandom_range(10, 0);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            chk.check_level(m_tdata);
        end
    end

    // Hold valid across back-to-back requests; drop it only for a gap.
    task automatic push_sample(input logic [tpm_pkg::SAMPLE_W-1:0] smp);
        int gap;
        if ($urandom_range(40, 0) == 0)
            tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(10, 0);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, smp};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        chk.take_sample(smp);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (chk.pending() > 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tpm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        chk.load_reg(idx, data);
    endtask

    task automatic load_config(input tpm_pkg::cfg_t c);
        logic [3:0] pad;
        pad = 4'($urandom);
        drain_results();
        repeat (4) @(posedge clk);
        write_reg(tpm_pkg::CFG_LEVEL1_TRIP, c.level1_trip);
        write_reg(tpm_pkg::CFG_LEVEL1_RELEASE, c.level1_release);
        write_reg(tpm_pkg::CFG_LEVEL2_TRIP, c.level2_trip);
        write_reg(tpm_pkg::CFG_LEVEL2_RELEASE, c.level2_release);
        // upper data bits are don't-care for the limit
        write_reg(tpm_pkg::CFG_DEBOUNCE_LIMIT, {pad, c.debounce_limit});
        if ($urandom_range(1, 0) == 1)
            write_reg(tpm_pkg::CFG_IDX_W'($urandom_range(7, CFG_LAST + 1)),
                      tpm_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic tpm_pkg::cfg_t make_cfg(input logic [tpm_pkg::SAMPLE_W-1:0] l1t,
                                               input logic [tpm_pkg::SAMPLE_W-1:0] l1r,
                                               input logic [tpm_pkg::SAMPLE_W-1:0] l2t,
                                               input logic [tpm_pkg::SAMPLE_W-1:0] l2r,
                                               input logic [tpm_pkg::COUNT_W-1:0] lim);
        tpm_pkg::cfg_t c;
        c.level1_trip    = l1t;
        c.level1_release = l1r;
        c.level2_trip    = l2t;
        c.level2_release = l2r;
        c.debounce_limit = lim;
        return c;
    endfunction

    // Mostly ordered thresholds as on a real board, sometimes scrambled.
    function automatic tpm_pkg::cfg_t random_config();
        int v[$];
        logic [tpm_pkg::COUNT_W-1:0] lim;
        repeat (4) v.push_back($urandom_range(4095, 0));
        if ($urandom_range(3, 0) != 0)
            v.sort();
        lim = ($urandom_range(3, 0) == 0) ? tpm_pkg::COUNT_W'($urandom_range(254, 0))
                                          : tpm_pkg::COUNT_W'($urandom_range(15, 0));
        return make_cfg(tpm_pkg::SAMPLE_W'(v[2]), tpm_pkg::SAMPLE_W'(v[3]),
                        tpm_pkg::SAMPLE_W'(v[0]), tpm_pkg::SAMPLE_W'(v[1]), lim);
    endfunction

    // Pick a sample that heats, cools or sits between thresholds at the current level.
    function automatic logic [tpm_pkg::SAMPLE_W-1:0] pick_sample(input pick_t kind);
        int lo;
        int hi;
        lo = 0;
        hi = 4095;
        case (chk.st.level)
            tpm_pkg::LEVEL_NORMAL:
            begin
                if (kind == PICK_HOT)
                    hi = int'(chk.regs.level1_trip) - 1;
                else if (kind != PICK_ANY)
                    lo = int'(chk.regs.level1_trip);
            end
            tpm_pkg::LEVEL_FIRST:
            begin
                case (kind)
                    PICK_HOT:  hi = int'(chk.regs.level2_trip) - 1;
                    PICK_COLD: lo = int'(chk.regs.level1_release) + 1;
                    PICK_MID:
                    begin
                        lo = int'(chk.regs.level2_trip);
                        hi = int'(chk.regs.level1_release);
                    end
                    default: ;
                endcase
            end
            default:
            begin
                if (kind == PICK_COLD)
                    lo = int'(chk.regs.level2_release) + 1;
                else if (kind != PICK_ANY)
                    hi = int'(chk.regs.level2_release);
            end
        endcase
        if (lo > hi)
        begin
            lo = 0;
            hi = 4095;
        end
        case ($urandom_range(7, 0))
            0: return tpm_pkg::SAMPLE_W'(lo);
            1: return tpm_pkg::SAMPLE_W'(hi);
            default: return tpm_pkg::SAMPLE_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // Runs of like samples, most long enough to move the level, some cut short.
    task automatic run_phase(input int n, input bit hold_midway);
        int done;
        int run;
        int lim;
        pick_t kind;
        done = 0;
        while (done < n)
        begin
            lim = chk.regs.debounce_limit;
            case ($urandom_range(9, 0))
                0, 1, 2, 3: kind = PICK_HOT;
                4, 5, 6:    kind = PICK_COLD;
                7:          kind = PICK_MID;
                default:    kind = PICK_ANY;
            endcase
            if (kind == PICK_ANY)
                run = $urandom_range(4, 1);
            else if ($urandom_range(3, 0) == 0)
                run = $urandom_range(lim + 1, 1);
            else
                run = $urandom_range(lim + 4, lim + 1);
            for (int r = 0; r < run && done < n; r++)
            begin
                push_sample(pick_sample(kind));
                done++;
                if (hold_midway && done == n / 2)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        int walk[$];
        int settle;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: extremes and the level-one trip edge
        walk = '{0, 4095, 944, 945, 946, 2730, 1365};
        foreach (walk[i])
            push_sample(tpm_pkg::SAMPLE_W'(walk[i]));

        // short debounce: walk every transition, leftover release count moves 2 -> 1
        load_config(make_cfg(tpm_pkg::RST_LEVEL1_TRIP, tpm_pkg::RST_LEVEL1_RELEASE,
                             tpm_pkg::RST_LEVEL2_TRIP, tpm_pkg::RST_LEVEL2_RELEASE, 8'd1));
        walk = '{944, 944, 1065, 740, 740, 864, 1064, 741, 1065, 1065, 0, 0, 0, 0, 863, 4095};
        foreach (walk[i])
            push_sample(tpm_pkg::SAMPLE_W'(walk[i]));

        load_config(make_cfg(12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd0));
        run_phase(60, 1'b0);
        load_config(make_cfg(12'd0, 12'd0, 12'd0, 12'd0, 8'd0));
        run_phase(60, 1'b0);
        // a limit of 255 lets the counters wrap without a level change
        load_config(make_cfg(tpm_pkg::RST_LEVEL1_TRIP, tpm_pkg::RST_LEVEL1_RELEASE,
                             tpm_pkg::RST_LEVEL2_TRIP, tpm_pkg::RST_LEVEL2_RELEASE, 8'd255));
        run_phase(350, 1'b0);
        load_config(make_cfg(12'd4095, 12'd0, 12'd4095, 12'd0,
                             tpm_pkg::COUNT_W'($urandom_range(5, 0))));
        run_phase(60, 1'b0);
        for (int p = 0; p < 6; p++)
        begin
            load_config(random_config());
            run_phase(65, p == 2);
        end

        s_tvalid <= 1'b0;
        settle = 0;
        while (chk.pending() > 0 && settle < 2000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (10) @(posedge clk);
        chk.finish_check();
        if (chk.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/tpm_pkg.sv
sv/tpm_level_update.sv
sv/thermal_protection_level_monitor_core.sv
tb/tb_top.sv
